>>> rtl/core/scef_pkg.sv
// ----------------------------------------------------------------------------
// scef_pkg
// Shared widths, event codes and sum limits for the symmetric CUSUM event filter.
// ----------------------------------------------------------------------------
package scef_pkg;

  // Sample and threshold width, Q16.16
  localparam int SAMPLE_W = 32;
  // Running sum width, same 16 fractional bits
  localparam int ACC_W    = 40;

  // Stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 2;
  localparam int EVENT_W     = 2;
  localparam int OUT_TDATA_W = ((EVENT_W + 7) / 8) * 8;

  // Event codes, two's complement in two bits
  localparam logic [EVENT_W-1:0] EV_NONE = 2'b00;
  localparam logic [EVENT_W-1:0] EV_UP   = 2'b01;
  localparam logic [EVENT_W-1:0] EV_DOWN = 2'b11;

  // Saturation limits of the running sums
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

>>> rtl/core/symmetric_cusum_event_filter_core.sv
// ----------------------------------------------------------------------------
// symmetric_cusum_event_filter_core
// Two-sided CUSUM filter: clamped upward and downward sums, one event per word.
// ----------------------------------------------------------------------------
// Takes one word per clock when the result side keeps up: each accepted input
// word yields exactly one result word in the next cycle, held in an output
// register until taken. The rate of one word per cycle is set by the running
// sum feedback loop, which is a single add, clamp and compare per sum between
// the sum registers. A new word is still taken while a finished result waits,
// as long as that result is taken in the same cycle. A word flagged as first
// of a series clears both sums and yields event 0. Events: -1 downward,
// 0 none, +1 upward; downward wins when both tests pass.
module symmetric_cusum_event_filter_core
  import scef_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] sample_change, [63:32] threshold
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [0] entry_allowed, [1] first_of_series
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [1:0] event_signal, rest zero
);

  localparam int SUM_W = ACC_W + 1;

  logic signed [ACC_W-1:0]   up_sum_r;
  logic signed [ACC_W-1:0]   up_sum_nxt;
  logic signed [ACC_W-1:0]   dn_sum_r;
  logic signed [ACC_W-1:0]   dn_sum_nxt;
  logic                      out_valid_r;
  logic [EVENT_W-1:0]        event_r;
  logic [EVENT_W-1:0]        event_nxt;

  logic                      in_fire;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] thr;
  logic                      entry_allowed;
  logic                      first_of_series;
  logic signed [SUM_W-1:0]   sample_x;
  logic signed [SUM_W-1:0]   thr_x;
  logic signed [SUM_W-1:0]   neg_thr_x;
  logic signed [SUM_W-1:0]   up_add;
  logic signed [SUM_W-1:0]   dn_add;
  logic signed [ACC_W-1:0]   up_acc;
  logic signed [ACC_W-1:0]   dn_acc;

  // Unpack the input word
  assign sample          = in_tdata[SAMPLE_W-1:0];
  assign thr             = in_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign entry_allowed   = in_tuser[0];
  assign first_of_series = in_tuser[1];

  // Accept while the result register is empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Widen operands so the sums and the negated threshold cannot wrap
  assign sample_x  = SUM_W'(sample);
  assign thr_x     = SUM_W'(thr);
  assign neg_thr_x = -thr_x;
  assign up_add    = SUM_W'(up_sum_r) + sample_x;
  assign dn_add    = SUM_W'(dn_sum_r) + sample_x;

  // Clamp upward sum to [0, max] and downward sum to [min, 0]
  always_comb begin
    if (up_add > SUM_W'(ACC_MAX)) begin
      up_acc = ACC_MAX;
    end else if (up_add < 0) begin
      up_acc = '0;
    end else begin
      up_acc = up_add[ACC_W-1:0];
    end
    if (dn_add < SUM_W'(ACC_MIN)) begin
      dn_acc = ACC_MIN;
    end else if (dn_add > 0) begin
      dn_acc = '0;
    end else begin
      dn_acc = dn_add[ACC_W-1:0];
    end
  end

  // Test thresholds; downward event has priority and clears only its sum
  always_comb begin
    up_sum_nxt = up_acc;
    dn_sum_nxt = dn_acc;
    event_nxt  = EV_NONE;
    if (first_of_series) begin
      up_sum_nxt = '0;
      dn_sum_nxt = '0;
    end else if (entry_allowed && (SUM_W'(dn_acc) < neg_thr_x)) begin
      dn_sum_nxt = '0;
      event_nxt  = EV_DOWN;
    end else if (entry_allowed && (SUM_W'(up_acc) > thr_x)) begin
      up_sum_nxt = '0;
      event_nxt  = EV_UP;
    end
  end

  // Advance the sums and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_sum_r    <= '0;
      dn_sum_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        up_sum_r <= up_sum_nxt;
        dn_sum_r <= dn_sum_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_r <= event_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(event_r);

`ifndef ASSERT_OFF
  // Upward sum never goes negative
  a_up_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !up_sum_r[ACC_W-1])
    else $error("upward sum negative");

  // Downward sum never goes positive
  a_dn_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    dn_sum_r[ACC_W-1] || (dn_sum_r == '0))
    else $error("downward sum positive");

  // A first-of-series word clears both sums and gives no event
  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && first_of_series |=>
      (up_sum_r == '0) && (dn_sum_r == '0) && (event_r == EV_NONE))
    else $error("first of series did not clear");

  // An upward event leaves the upward sum cleared
  a_up_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (event_nxt == EV_UP) |=> (up_sum_r == '0))
    else $error("upward event did not clear sum");

  // Result code is never the unused pattern
  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (event_r == EV_NONE) || (event_r == EV_UP) || (event_r == EV_DOWN))
    else $error("bad event code");
`endif

endmodule

>>> verif/symmetric_cusum_event_filter_core_test.sv
// ----------------------------------------------------------------------------
// symmetric_cusum_event_filter_core_test
// Self-checking bench for the two-sided CUSUM event filter.
// ----------------------------------------------------------------------------
// Words go in on the input stream and are mirrored by a scoreboard that keeps
// its own upward and downward sums and predicts the event of every word.
// Each result word is compared against the oldest prediction. The stimulus
// opens with hand-picked corner words, then runs series of random samples
// under varied scales and thresholds, a few noise stretches, and long
// saturating runs in both directions. Both sides idle in random bursts in
// randomly chosen stretches, but not in the corner words or closing stretch.
module symmetric_cusum_event_filter_core_test;
  import scef_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Sum limits as plain 64-bit numbers for the predictor
  localparam longint SUM_CEIL  = ACC_MAX;
  localparam longint SUM_FLOOR = ACC_MIN;

  // Tracks the running sums and checks result words in order
  class event_scoreboard;
    logic [EVENT_W-1:0] event_q[$];
    longint             up_sum;
    longint             down_sum;
    int                 errors;

    function new();
      up_sum   = 0;
      down_sum = 0;
      errors   = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Advance the sums for one accepted word and queue its event
    function void note_input(logic [IN_TDATA_W-1:0] data, logic [IN_TUSER_W-1:0] user);
      logic signed [SAMPLE_W-1:0] chg;
      logic signed [SAMPLE_W-1:0] thr;
      longint                     s;
      longint                     t;
      logic [EVENT_W-1:0]         ev;
      chg = data[SAMPLE_W-1:0];
      thr = data[2*SAMPLE_W-1:SAMPLE_W];
      s   = longint'(chg);
      t   = longint'(thr);
      ev  = EV_NONE;
      if (user[1]) begin
        up_sum   = 0;
        down_sum = 0;
      end else begin
        // up sum clamps at zero and saturates high; down sum mirrors it
        up_sum += s;
        if (up_sum > SUM_CEIL) up_sum = SUM_CEIL;
        else if (up_sum < 0) up_sum = 0;
        down_sum += s;
        if (down_sum < SUM_FLOOR) down_sum = SUM_FLOOR;
        else if (down_sum > 0) down_sum = 0;
        // downward test takes priority
        if (user[0] && down_sum < -t) begin
          down_sum = 0;
          ev = EV_DOWN;
        end else if (user[0] && up_sum > t) begin
          up_sum = 0;
          ev = EV_UP;
        end
      end
      event_q.push_back(ev);
    endfunction

    // Compare one result word with the oldest prediction
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      logic [OUT_TDATA_W-1:0] want;
      if (event_q.size() == 0) begin
        flag($sformatf("result %h with nothing pending", data));
        return;
      end
      want = '0;
      want[EVENT_W-1:0] = event_q.pop_front();
      if (data[EVENT_W-1:0] !== want[EVENT_W-1:0])
        flag($sformatf("event expected %b actual %b", want[EVENT_W-1:0],
                       data[EVENT_W-1:0]));
      if (data[OUT_TDATA_W-1:EVENT_W] !== want[OUT_TDATA_W-1:EVENT_W])
        flag($sformatf("pad bits expected %h actual %h",
                       want[OUT_TDATA_W-1:EVENT_W], data[OUT_TDATA_W-1:EVENT_W]));
    endfunction

    function void flag_leftover();
      if (event_q.size() != 0)
        flag($sformatf("%0d results never arrived", event_q.size()));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;

  event_scoreboard sb = new();

  symmetric_cusum_event_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Result side: ready with random stall bursts
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Hold one word on the input until it is taken, with an optional gap first
  task automatic send_word(logic [SAMPLE_W-1:0] chg, logic [SAMPLE_W-1:0] thr,
                           bit allow, bit first);
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {thr, chg};
    in_tuser  <= {first, allow};
    do @(posedge clk); while (!in_tready);
  endtask

  // Signed value with a random magnitude of up to the given number of bits
  function automatic logic [SAMPLE_W-1:0] draw_value(int bits);
    logic [SAMPLE_W-1:0] v;
    v = $urandom;
    if (bits < SAMPLE_W) v = v & ((SAMPLE_W'(1) << bits) - 1);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // Random series: clear, then samples around a drift at one scale
  task automatic run_series(int len);
    int                  scale;
    logic [SAMPLE_W-1:0] drift;
    logic [SAMPLE_W-1:0] thr;
    bit                  allow;
    scale = $urandom_range(4, 26);
    drift = draw_value(scale - 2);
    send_word(draw_value(SAMPLE_W), draw_value(SAMPLE_W), 1'($urandom_range(0, 1)), 1'b1);
    repeat (len) begin
      if ($urandom_range(0, 11) == 0) thr = draw_value(SAMPLE_W);
      else thr = $urandom & ((SAMPLE_W'(1) << (scale + $urandom_range(0, 4))) - 1);
      allow = ($urandom_range(0, 7) != 0);
      send_word(drift + draw_value(scale), thr, allow, 1'b0);
    end
  endtask

  // Long run of extreme samples that drives one sum into saturation
  task automatic run_saturation(bit upward);
    logic [SAMPLE_W-1:0] extreme;
    extreme = upward ? {1'b0, {(SAMPLE_W-1){1'b1}}} : {1'b1, {(SAMPLE_W-1){1'b0}}};
    send_word('0, '0, 1'b0, 1'b1);
    repeat (262) send_word(extreme, $urandom, 1'b0, 1'b0);
    // back off a little, then release with the widest threshold
    repeat (3) send_word(draw_value(20), $urandom, 1'b0, 1'b0);
    send_word('0, {1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b1, 1'b0);
    send_word(extreme, '0, 1'b1, 1'b0);
  endtask

  // Corner words: extremes, priority, blocked entry, negative thresholds
  localparam int N_CORNER = 15;
  localparam logic [SAMPLE_W-1:0] CORNER_CHG [N_CORNER] = '{
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
    32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFB, 32'h8000_0000,
    32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
  localparam logic [SAMPLE_W-1:0] CORNER_THR [N_CORNER] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_000A, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
  localparam bit [N_CORNER-1:0] CORNER_ALLOW = 15'b111_1111_0110_1111;
  localparam bit [N_CORNER-1:0] CORNER_FIRST = 15'b000_0010_0000_0001;

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_CORNER; i++)
      send_word(CORNER_CHG[i], CORNER_THR[i], CORNER_ALLOW[i], CORNER_FIRST[i]);

    // Random series with idling switched per stretch
    for (int k = 0; k < 30; k++) begin
      tx_idle_on = $urandom_range(0, 2) != 0;
      rx_idle_on = $urandom_range(0, 2) != 0;
      if (k == 8) run_saturation(1'b1);
      else if (k == 20) run_saturation(1'b0);
      else if (k % 7 == 3) begin
        repeat (15) send_word($urandom, $urandom, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
      end else run_series($urandom_range(4, 30));
    end

    // Closing stretch without idling
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (6) run_series($urandom_range(10, 30));

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.event_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.flag_leftover();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
